// ----- src/acr_pkg.sv -----
// Shared types, widths and helpers for the box collision resolver.
package acr_pkg;

    localparam int MAX_OBSTACLES = 8;
    localparam int COORD_BITS    = 16;

    localparam int SIZE_BITS  = 15;
    localparam int HALF_BITS  = SIZE_BITS - 1;
    localparam int COUNT_BITS = 4;
    localparam int ENTRY_BITS = 3;
    localparam int HIT_BITS   = 4;

    localparam int IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
    // common width for comparing cell index against count / entry index
    localparam int CMP_W = ((IDX_W > COUNT_BITS) ? IDX_W : COUNT_BITS) + 1;

    // extended width for bounds, pushes and overlaps
    localparam int EXT_W = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 3;

    localparam int HIT_SAT = 15;
    localparam int HIT_MAX = (MAX_OBSTACLES < HIT_SAT) ? MAX_OBSTACLES : HIT_SAT;

    // input tdata layout
    localparam int IN_ENTRY_LSB = 0;
    localparam int IN_OX_LSB    = IN_ENTRY_LSB + ENTRY_BITS;
    localparam int IN_OY_LSB    = IN_OX_LSB + COORD_BITS;
    localparam int IN_OW_LSB    = IN_OY_LSB + COORD_BITS;
    localparam int IN_OH_LSB    = IN_OW_LSB + SIZE_BITS;
    localparam int IN_TX_LSB    = IN_OH_LSB + SIZE_BITS;
    localparam int IN_TY_LSB    = IN_TX_LSB + COORD_BITS;
    localparam int IN_BITS      = IN_TY_LSB + COORD_BITS;
    localparam int IN_DATA_W    = ((IN_BITS + 7) / 8) * 8;

    // output tdata layout
    localparam int OUT_RX_LSB  = 0;
    localparam int OUT_RY_LSB  = OUT_RX_LSB + COORD_BITS;
    localparam int OUT_HIT_LSB = OUT_RY_LSB + COORD_BITS;
    localparam int OUT_BITS    = OUT_HIT_LSB + HIT_BITS;
    localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = SIZE_BITS;

    localparam logic [SIZE_BITS-1:0] MOVER_SIZE_RESET = SIZE_BITS'(512);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_OBSTACLE_COUNT = 2'd0,
        CFG_MOVER_WIDTH    = 2'd1,
        CFG_MOVER_HEIGHT   = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        REQ_WRITE   = 1'b0,
        REQ_RESOLVE = 1'b1
    } req_t;

    typedef struct packed {
        logic                         valid;
        req_t                         req_type;
        logic [ENTRY_BITS-1:0]        entry_index;
        logic signed [COORD_BITS-1:0] obs_x;
        logic signed [COORD_BITS-1:0] obs_y;
        logic [SIZE_BITS-1:0]         obs_w;
        logic [SIZE_BITS-1:0]         obs_h;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic [HIT_BITS-1:0]          hits;
    } item_t;

    typedef struct packed {
        logic                    active;
        logic signed [EXT_W-1:0] lo_p_x;
        logic signed [EXT_W-1:0] hi_p_x;
        logic signed [EXT_W-1:0] lo_p_y;
        logic signed [EXT_W-1:0] hi_p_y;
        logic signed [EXT_W-1:0] lo_o_x;
        logic signed [EXT_W-1:0] hi_o_x;
        logic signed [EXT_W-1:0] lo_o_y;
        logic signed [EXT_W-1:0] hi_o_y;
        logic signed [EXT_W-1:0] push_l;
        logic signed [EXT_W-1:0] push_r;
        logic signed [EXT_W-1:0] push_d;
        logic signed [EXT_W-1:0] push_u;
        logic signed [EXT_W-1:0] ctr_x;
        logic signed [EXT_W-1:0] ctr_y;
    } geom_t;

    function automatic logic signed [COORD_BITS-1:0] sat_coord(
        input logic signed [EXT_W-1:0] v
    );
        logic signed [EXT_W-1:0] hi;
        logic signed [EXT_W-1:0] lo;
        hi = EXT_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
        lo = -hi - EXT_W'(1);
        if (v > hi)
        begin
            return hi[COORD_BITS-1:0];
        end
        else if (v < lo)
        begin
            return lo[COORD_BITS-1:0];
        end
        return v[COORD_BITS-1:0];
    endfunction

endpackage

// ----- src/acr_cell.sv -----
// One obstacle cell: owns one table entry, two pipeline stages (bounds, then push).
module acr_cell
    import acr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic [IDX_W-1:0]      cell_index,
    input  logic [COUNT_BITS-1:0] obstacle_count,
    input  logic [HALF_BITS-1:0]  mover_half_x,
    input  logic [HALF_BITS-1:0]  mover_half_y,
    input  item_t                 item_in,
    output item_t                 item_out
);

    logic signed [COORD_BITS-1:0] ent_x_reg;
    logic signed [COORD_BITS-1:0] ent_y_reg;
    logic [SIZE_BITS-1:0]         ent_w_reg;
    logic [SIZE_BITS-1:0]         ent_h_reg;

    item_t item_a_reg;
    geom_t geom_a_reg;
    geom_t geom_next;
    item_t item_b_reg;
    item_t item_b_next;

    logic entry_match;
    logic in_range;

    logic signed [EXT_W-1:0] px;
    logic signed [EXT_W-1:0] py;
    logic signed [EXT_W-1:0] ox;
    logic signed [EXT_W-1:0] oy;
    logic signed [EXT_W-1:0] mhx;
    logic signed [EXT_W-1:0] mhy;
    logic signed [EXT_W-1:0] ohx;
    logic signed [EXT_W-1:0] ohy;

    logic                    overlap;
    logic signed [EXT_W-1:0] ovx_a;
    logic signed [EXT_W-1:0] ovx_b;
    logic signed [EXT_W-1:0] ovy_a;
    logic signed [EXT_W-1:0] ovy_b;
    logic signed [EXT_W-1:0] ovx;
    logic signed [EXT_W-1:0] ovy;
    logic signed [EXT_W-1:0] cur_x;
    logic signed [EXT_W-1:0] cur_y;

    assign entry_match = CMP_W'(item_in.entry_index) == CMP_W'(cell_index);
    assign in_range    = CMP_W'(cell_index) < CMP_W'(obstacle_count);

    // The write beat updates the entry when it passes this cell, so beats ahead of it
    // see the old entry and beats behind it see the new one.
    always_ff @(posedge clk)
    begin
        if (adv && item_in.valid && item_in.req_type == REQ_WRITE && entry_match)
        begin
            ent_x_reg <= item_in.obs_x;
            ent_y_reg <= item_in.obs_y;
            ent_w_reg <= item_in.obs_w;
            ent_h_reg <= item_in.obs_h;
        end
    end

    // stage A: box bounds and candidate push positions
    always_comb
    begin
        px  = EXT_W'(item_in.pos_x);
        py  = EXT_W'(item_in.pos_y);
        ox  = EXT_W'(ent_x_reg);
        oy  = EXT_W'(ent_y_reg);
        mhx = EXT_W'($signed({1'b0, mover_half_x}));
        mhy = EXT_W'($signed({1'b0, mover_half_y}));
        ohx = EXT_W'($signed({2'b00, ent_w_reg[SIZE_BITS-1:1]}));
        ohy = EXT_W'($signed({2'b00, ent_h_reg[SIZE_BITS-1:1]}));

        geom_next.active = item_in.req_type == REQ_RESOLVE && in_range;
        geom_next.lo_p_x = px - mhx;
        geom_next.hi_p_x = px + mhx;
        geom_next.lo_p_y = py - mhy;
        geom_next.hi_p_y = py + mhy;
        geom_next.lo_o_x = ox - ohx;
        geom_next.hi_o_x = ox + ohx;
        geom_next.lo_o_y = oy - ohy;
        geom_next.hi_o_y = oy + ohy;
        geom_next.push_l = ox - ohx - mhx;
        geom_next.push_r = ox + ohx + mhx;
        geom_next.push_d = oy - ohy - mhy;
        geom_next.push_u = oy + ohy + mhy;
        geom_next.ctr_x  = ox;
        geom_next.ctr_y  = oy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_a_reg.valid <= 1'b0;
        end
        else if (adv)
        begin
            item_a_reg <= item_in;
            geom_a_reg <= geom_next;
        end
    end

    // stage B: strict overlap test, smaller-axis push, saturation
    always_comb
    begin
        overlap = (geom_a_reg.lo_p_x < geom_a_reg.hi_o_x) &&
                  (geom_a_reg.hi_p_x > geom_a_reg.lo_o_x) &&
                  (geom_a_reg.lo_p_y < geom_a_reg.hi_o_y) &&
                  (geom_a_reg.hi_p_y > geom_a_reg.lo_o_y);
        ovx_a = geom_a_reg.hi_p_x - geom_a_reg.lo_o_x;
        ovx_b = geom_a_reg.hi_o_x - geom_a_reg.lo_p_x;
        ovy_a = geom_a_reg.hi_p_y - geom_a_reg.lo_o_y;
        ovy_b = geom_a_reg.hi_o_y - geom_a_reg.lo_p_y;
        ovx   = (ovx_a < ovx_b) ? ovx_a : ovx_b;
        ovy   = (ovy_a < ovy_b) ? ovy_a : ovy_b;
        cur_x = EXT_W'(item_a_reg.pos_x);
        cur_y = EXT_W'(item_a_reg.pos_y);

        item_b_next = item_a_reg;
        if (geom_a_reg.active && overlap)
        begin
            // tie goes vertical
            if (ovx < ovy)
            begin
                item_b_next.pos_x = sat_coord((cur_x < geom_a_reg.ctr_x) ?
                                              geom_a_reg.push_l : geom_a_reg.push_r);
            end
            else
            begin
                item_b_next.pos_y = sat_coord((cur_y < geom_a_reg.ctr_y) ?
                                              geom_a_reg.push_d : geom_a_reg.push_u);
            end
            if (item_a_reg.hits != HIT_BITS'(HIT_SAT))
            begin
                item_b_next.hits = item_a_reg.hits + HIT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_b_reg.valid <= 1'b0;
        end
        else if (adv)
        begin
            item_b_reg <= item_b_next;
        end
    end

    assign item_out = item_b_reg;

endmodule

// ----- src/aabb_collision_resolver_core.sv -----
// Top level: config registers, beat unpacking and the chain of obstacle cells.
//
// Usage:
//   s_* carries one request per beat. s_tuser selects the kind: a write beat stores
//   one obstacle entry, a resolve beat brings a target center for the mover box.
//   m_* returns exactly one result beat per request, in request order: the
//   resolved center and hit count, or all zeros for a write beat.
//   cfg_we / cfg_index / cfg_data write obstacle_count, mover_width, mover_height;
//   write them only while no request is in flight.
// Timing:
//   One cell per table entry, two register stages per cell. A new request can
//   enter every cycle while the output is not stalled; a write reaches each entry
//   in order with the resolves, so a resolve sees exactly the writes accepted
//   before it.
// Reset:
//   Clears all valid bits and the config registers (count 0, mover 512 x 512).
//   Table entries are undefined until written.
// Stall:
//   The last cell stage is the output register; while it holds a beat that is not
//   taken, the whole chain freezes and s_tready drops. Nothing is lost or repeated.
module aabb_collision_resolver_core
    import acr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // entry_index, obstacle_x, obstacle_y, obstacle_width, obstacle_height,
    // target_x, target_y (from bit 0 up), zero padded
    input  logic [IN_DATA_W-1:0]   s_tdata,
    // req_type
    input  logic [0:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // resolved_x, resolved_y, hit_count (from bit 0 up), zero padded
    output logic [OUT_DATA_W-1:0]  m_tdata,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [COUNT_BITS-1:0] obstacle_count_reg;
    logic [SIZE_BITS-1:0]  mover_width_reg;
    logic [SIZE_BITS-1:0]  mover_height_reg;

    item_t chain [MAX_OBSTACLES+1];
    item_t last_item;
    logic  adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obstacle_count_reg <= '0;
            mover_width_reg    <= MOVER_SIZE_RESET;
            mover_height_reg   <= MOVER_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_OBSTACLE_COUNT: obstacle_count_reg <= cfg_data[COUNT_BITS-1:0];
                CFG_MOVER_WIDTH:    mover_width_reg    <= cfg_data;
                CFG_MOVER_HEIGHT:   mover_height_reg   <= cfg_data;
                default:            ;
            endcase
        end
    end

    assign adv      = !last_item.valid || m_tready;
    assign s_tready = adv;

    always_comb
    begin
        chain[0].valid       = s_tvalid;
        chain[0].req_type    = req_t'(s_tuser[0]);
        chain[0].entry_index = s_tdata[IN_ENTRY_LSB +: ENTRY_BITS];
        chain[0].obs_x       = s_tdata[IN_OX_LSB +: COORD_BITS];
        chain[0].obs_y       = s_tdata[IN_OY_LSB +: COORD_BITS];
        chain[0].obs_w       = s_tdata[IN_OW_LSB +: SIZE_BITS];
        chain[0].obs_h       = s_tdata[IN_OH_LSB +: SIZE_BITS];
        chain[0].pos_x       = s_tdata[IN_TX_LSB +: COORD_BITS];
        chain[0].pos_y       = s_tdata[IN_TY_LSB +: COORD_BITS];
        chain[0].hits        = '0;
    end

    for (genvar i = 0; i < MAX_OBSTACLES; i++)
    begin : g_cell
        acr_cell u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .adv            (adv),
            .cell_index     (IDX_W'(i)),
            .obstacle_count (obstacle_count_reg),
            .mover_half_x   (mover_width_reg[SIZE_BITS-1:1]),
            .mover_half_y   (mover_height_reg[SIZE_BITS-1:1]),
            .item_in        (chain[i]),
            .item_out       (chain[i+1])
        );
    end

    assign last_item = chain[MAX_OBSTACLES];
    assign m_tvalid  = last_item.valid;

    always_comb
    begin
        m_tdata = '0;
        if (last_item.req_type == REQ_RESOLVE)
        begin
            m_tdata[OUT_RX_LSB +: COORD_BITS] = last_item.pos_x;
            m_tdata[OUT_RY_LSB +: COORD_BITS] = last_item.pos_y;
            m_tdata[OUT_HIT_LSB +: HIT_BITS]  = last_item.hits;
        end
    end

endmodule

// ----- src/acr_checker.sv -----
// Port-level checks for the collision resolver, bound to the top level.
module acr_checker
    import acr_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // a stalled result beat stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed while stalled");

    // input side only stalls when the output register is full and not taken
    a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output stall");

    // one push per cell at most
    a_hit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_HIT_LSB +: HIT_BITS] <= HIT_BITS'(HIT_MAX))
        else $error("hit count above table size");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("output valid during reset");

endmodule

bind aabb_collision_resolver_core acr_checker u_acr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
